[rtl/crcp_pkg.sv]
// shared types and constants for the catmull-rom closest point unit
package crcp_pkg;

  localparam int MaxPoints     = 16;
  localparam int CoarseSamples = 128;
  localparam int GoldenRounds  = 24;
  localparam int IdxW          = $clog2(MaxPoints);
  localparam int SegW          = IdxW;
  localparam int SampW         = $clog2(CoarseSamples + 1);
  localparam int RoundW        = $clog2(GoldenRounds + 1);
  localparam int NSegs         = MaxPoints - 3;

  localparam logic [16:0] TOne    = 17'h10000;
  localparam logic [15:0] InvPhi  = 16'd40504;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // samples per segment, indexed by segment count minus one
  localparam logic [0:NSegs-1][SampW-1:0] SppTab = '{
    SampW'(CoarseSamples / 1),  SampW'(CoarseSamples / 2),  SampW'(CoarseSamples / 3),
    SampW'(CoarseSamples / 4),  SampW'(CoarseSamples / 5),  SampW'(CoarseSamples / 6),
    SampW'(CoarseSamples / 7),  SampW'(CoarseSamples / 8),  SampW'(CoarseSamples / 9),
    SampW'(CoarseSamples / 10), SampW'(CoarseSamples / 11), SampW'(CoarseSamples / 12),
    SampW'(CoarseSamples / 13)
  };

  // sample grid step 65536/(spp-1): quotient and remainder
  localparam logic [0:NSegs-1][16:0] StepQTab = '{
    17'(65536 / (CoarseSamples / 1 - 1)),  17'(65536 / (CoarseSamples / 2 - 1)),
    17'(65536 / (CoarseSamples / 3 - 1)),  17'(65536 / (CoarseSamples / 4 - 1)),
    17'(65536 / (CoarseSamples / 5 - 1)),  17'(65536 / (CoarseSamples / 6 - 1)),
    17'(65536 / (CoarseSamples / 7 - 1)),  17'(65536 / (CoarseSamples / 8 - 1)),
    17'(65536 / (CoarseSamples / 9 - 1)),  17'(65536 / (CoarseSamples / 10 - 1)),
    17'(65536 / (CoarseSamples / 11 - 1)), 17'(65536 / (CoarseSamples / 12 - 1)),
    17'(65536 / (CoarseSamples / 13 - 1))
  };

  localparam logic [0:NSegs-1][SampW-1:0] StepRTab = '{
    SampW'(65536 % (CoarseSamples / 1 - 1)),  SampW'(65536 % (CoarseSamples / 2 - 1)),
    SampW'(65536 % (CoarseSamples / 3 - 1)),  SampW'(65536 % (CoarseSamples / 4 - 1)),
    SampW'(65536 % (CoarseSamples / 5 - 1)),  SampW'(65536 % (CoarseSamples / 6 - 1)),
    SampW'(65536 % (CoarseSamples / 7 - 1)),  SampW'(65536 % (CoarseSamples / 8 - 1)),
    SampW'(65536 % (CoarseSamples / 9 - 1)),  SampW'(65536 % (CoarseSamples / 10 - 1)),
    SampW'(65536 % (CoarseSamples / 11 - 1)), SampW'(65536 % (CoarseSamples / 12 - 1)),
    SampW'(65536 % (CoarseSamples / 13 - 1))
  };

  typedef logic signed [31:0] coord_t;
  typedef logic [63:0] dist_t;

  // signed control points, four per axis
  typedef struct packed {
    coord_t [3:0] px;
    coord_t [3:0] py;
  } seg_pts_t;

  // request to the shared evaluator
  typedef struct packed {
    logic        start;
    logic [16:0] t;
    coord_t      qx;
    coord_t      qy;
  } eval_req_t;

  // answer from the shared evaluator
  typedef struct packed {
    logic   done;
    coord_t x;
    coord_t y;
    dist_t  dsq;
  } eval_rsp_t;

endpackage

[rtl/catmull_rom_closest_point_unit.sv]
// top level: control point table, search sequencer and result register
// a query evaluates (samples + 2*24 + 1) spline points on the shared
// evaluator. one item at a time: in_ready is low while a query runs and
// while a result waits. rst_n clears control state and sets point_count
// to 4; the control point table is undefined until written
module catmull_rom_closest_point_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [4:0]             cfg_point_count,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [3:0]             in_point_index,
  input  logic signed [31:0]     in_coord_x,
  input  logic signed [31:0]     in_coord_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     out_closest_x,
  output logic signed [31:0]     out_closest_y,
  output logic [15:0]            out_curve_param,
  output logic [3:0]             out_segment_index
);
  import crcp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_COARSE = 6'b000010,
    S_GOLD   = 6'b000100,
    S_FINAL  = 6'b001000,
    S_WAIT   = 6'b010000,
    S_OUT    = 6'b100000
  } st_t;

  st_t st_r, st_nxt;
  logic [4:0] count_r;
  logic [63:0] mem_r [MaxPoints];
  seg_pts_t pts;
  eval_req_t req;
  eval_rsp_t rsp;

  coord_t qx_r, qy_r;
  logic [SegW-1:0] seg_r, best_seg_r, nsegs_r;
  logic [SampW-1:0] j_r, spp_r;
  logic [16:0] tsamp_r, tnum_r;  // floor(j*65536/(spp-1)) by running remainder
  logic [SampW-1:0] trem_r, trstep_r;
  logic found_r;
  dist_t best_r, d1_r;
  logic [16:0] a_r, b_r, k_r;
  logic [RoundW-1:0] round_r;
  logic probe_r;  // 0 probe t1, 1 probe t2
  logic busy_r;   // evaluator launched
  logic [16:0] t_final;
  logic [4:0] ncl;
  logic [3:0] cnt_slot;
  logic [33:0] kmul;

  assign cfg_ready = (st_r == S_IDLE);
  assign in_ready  = (st_r == S_IDLE) && !cfg_valid;
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pts.px[k] = mem_r[IdxW'(seg_r + SegW'(k))][63:32];
      pts.py[k] = mem_r[IdxW'(seg_r + SegW'(k))][31:0];
    end
  end

  crcp_eval u_eval (.clk(clk), .rst_n(rst_n), .pts(pts), .req(req), .rsp(rsp));

  always_comb begin
    ncl = count_r;
    if (ncl < 5'd4) ncl = 5'd4;
    if (ncl > 5'(MaxPoints)) ncl = 5'(MaxPoints);
    cnt_slot = 4'(ncl - 5'd4);
    kmul = 34'(b_r - a_r) * 34'(InvPhi);
    t_final = 17'((18'(a_r) + 18'(b_r)) >> 1);
    if (t_final > 17'd65535) t_final = 17'd65535;
  end

  always_comb begin
    req.qx = qx_r;
    req.qy = qy_r;
    req.start = 1'b0;
    req.t = tsamp_r;
    unique case (st_r)
      S_COARSE: begin req.start = !busy_r; req.t = tsamp_r; end
      S_GOLD:   begin
        req.start = !busy_r;
        req.t = probe_r ? 17'(a_r + k_r) : 17'(b_r - k_r);
      end
      S_FINAL:  begin req.start = !busy_r; req.t = t_final; end
      default:  ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid && in_ready && in_operation == OpQuery) st_nxt = S_COARSE;
      S_COARSE: if (rsp.done && j_r == spp_r - SampW'(1) && seg_r == nsegs_r - SegW'(1))
        st_nxt = S_GOLD;
      S_GOLD: if (rsp.done && probe_r && round_r == RoundW'(GoldenRounds - 1))
        st_nxt = S_FINAL;
      S_FINAL: if (rsp.done) st_nxt = S_OUT;
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      count_r <= 5'd4;
      busy_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) count_r <= cfg_point_count;
      if (rsp.done) busy_r <= 1'b0;
      else if (req.start) busy_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_operation == OpWrite)
      mem_r[in_point_index] <= {in_coord_x, in_coord_y};
    unique case (st_r)
      S_IDLE: begin
        qx_r <= in_coord_x;
        qy_r <= in_coord_y;
        seg_r <= '0;
        nsegs_r <= SegW'(ncl - 5'd3);
        spp_r <= SppTab[cnt_slot];
        tnum_r <= StepQTab[cnt_slot];
        trstep_r <= StepRTab[cnt_slot];
        j_r <= '0;
        tsamp_r <= '0;
        trem_r <= '0;
        found_r <= 1'b0;
        best_seg_r <= '0;
        a_r <= '0;
        b_r <= TOne;
        round_r <= '0;
        probe_r <= 1'b0;
      end
      S_COARSE: if (rsp.done) begin
        if (!found_r || rsp.dsq < best_r) begin
          found_r <= 1'b1;
          best_r <= rsp.dsq;
          best_seg_r <= seg_r;
        end
        // advance t by 65536/(spp-1) using quotient/remainder stepping
        if (j_r == spp_r - SampW'(1)) begin
          j_r <= '0;
          tsamp_r <= '0;
          trem_r <= '0;
          if (seg_r == nsegs_r - SegW'(1)) begin
            seg_r <= (!found_r || rsp.dsq < best_r) ? seg_r : best_seg_r;
            k_r <= 17'((kmul + 34'd32768) >> 16);
          end else begin
            seg_r <= seg_r + SegW'(1);
          end
        end else begin
          j_r <= j_r + SampW'(1);
          if (18'(trem_r) + 18'(trstep_r) >= 18'(spp_r - SampW'(1))) begin
            tsamp_r <= tsamp_r + tnum_r + 17'd1;
            trem_r <= SampW'(18'(trem_r) + 18'(trstep_r) - 18'(spp_r - SampW'(1)));
          end else begin
            tsamp_r <= tsamp_r + tnum_r;
            trem_r <= trem_r + trstep_r;
          end
        end
      end
      S_GOLD: if (rsp.done) begin
        if (!probe_r) begin
          d1_r <= rsp.dsq;
          probe_r <= 1'b1;
        end else begin
          probe_r <= 1'b0;
          round_r <= round_r + RoundW'(1);
          if (d1_r < rsp.dsq) begin
            b_r <= 17'(a_r + k_r);
            k_r <= 17'(((34'(17'(a_r + k_r) - a_r) * 34'(InvPhi)) + 34'd32768) >> 16);
          end else begin
            a_r <= 17'(b_r - k_r);
            k_r <= 17'(((34'(b_r - 17'(b_r - k_r)) * 34'(InvPhi)) + 34'd32768) >> 16);
          end
        end
      end
      S_FINAL: if (rsp.done) begin
        out_closest_x <= rsp.x;
        out_closest_y <= rsp.y;
        out_curve_param <= t_final[15:0];
        out_segment_index <= best_seg_r;
      end
      default: ;
    endcase
  end

endmodule

[rtl/crcp_eval.sv]
// shared multi-cycle spline evaluator with squared distance to the query
module crcp_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  crcp_pkg::seg_pts_t  pts,
  input  crcp_pkg::eval_req_t req,
  output crcp_pkg::eval_rsp_t rsp
);
  import crcp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_T2   = 10'b0000000010,
    S_T3   = 10'b0000000100,
    S_COEF = 10'b0000001000,
    S_M1   = 10'b0000010000,
    S_M2   = 10'b0000100000,
    S_M3   = 10'b0001000000,
    S_AXIS = 10'b0010000000,
    S_SQ   = 10'b0100000000,
    S_SUM  = 10'b1000000000
  } st_t;

  st_t st_r, st_nxt;
  logic        axis_r, axis_nxt;
  logic [16:0] t_r, t2_r, t3_r;
  logic signed [35:0] c1_r, c2_r, c3_r;
  logic signed [35:0] c0_r;
  logic signed [70:0] acc_r;
  coord_t x_r, y_r;
  logic [63:0] sx_r, sy_r;
  coord_t qx_r, qy_r;
  logic done_r;
  dist_t dsq_r;

  // one shared signed multiplier 36 x 18
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;
  logic [33:0] tsq;
  logic signed [35:0] p0, p1, p2, p3;
  logic signed [70:0] rnd;
  logic signed [53:0] shf;
  coord_t ax_v;
  logic [32:0] dabs;
  logic [63:0] sq;
  logic [64:0] sum;

  always_comb begin
    p0 = axis_r ? 36'(pts.py[0]) : 36'(pts.px[0]);
    p1 = axis_r ? 36'(pts.py[1]) : 36'(pts.px[1]);
    p2 = axis_r ? 36'(pts.py[2]) : 36'(pts.px[2]);
    p3 = axis_r ? 36'(pts.py[3]) : 36'(pts.px[3]);
  end

  always_comb begin
    mul_a = c1_r;
    mul_b = $signed({1'b0, t_r});
    unique case (st_r)
      S_M2:    begin mul_a = c2_r; mul_b = $signed({1'b0, t2_r}); end
      S_M3:    begin mul_a = c3_r; mul_b = $signed({1'b0, t3_r}); end
      default: begin mul_a = c1_r; mul_b = $signed({1'b0, t_r}); end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    tsq = (st_r == S_T2) ? 34'(t_r) * 34'(t_r) : 34'(t2_r) * 34'(t_r);
    rnd = acc_r + 71'sd65536;
    shf = 54'(rnd >>> 17);
    if (shf > 54'sd2147483647) ax_v = 32'sh7fffffff;
    else if (shf < -54'sd2147483648) ax_v = 32'sh80000000;
    else ax_v = shf[31:0];
    dabs = (axis_r ? y_r : x_r) >= (axis_r ? qy_r : qx_r) ?
           33'($signed({(axis_r ? y_r[31] : x_r[31]), (axis_r ? y_r : x_r)}) -
               $signed({(axis_r ? qy_r[31] : qx_r[31]), (axis_r ? qy_r : qx_r)})) :
           33'($signed({(axis_r ? qy_r[31] : qx_r[31]), (axis_r ? qy_r : qx_r)}) -
               $signed({(axis_r ? y_r[31] : x_r[31]), (axis_r ? y_r : x_r)}));
    sq  = 64'(dabs) * 64'(dabs);
    sum = 65'(sx_r) + 65'(sy_r);
  end

  always_comb begin
    st_nxt   = st_r;
    axis_nxt = axis_r;
    unique case (st_r)
      S_IDLE: if (req.start) begin st_nxt = S_T2; axis_nxt = 1'b0; end
      S_T2:   st_nxt = S_T3;
      S_T3:   st_nxt = S_COEF;
      S_COEF: st_nxt = S_M1;
      S_M1:   st_nxt = S_M2;
      S_M2:   st_nxt = S_M3;
      S_M3:   st_nxt = S_AXIS;
      S_AXIS: begin
        if (axis_r) begin
          st_nxt = S_SQ;
          axis_nxt = 1'b0;
        end else begin
          st_nxt = S_COEF;
          axis_nxt = 1'b1;
        end
      end
      S_SQ:   begin
        if (axis_r) st_nxt = S_SUM;
        axis_nxt = ~axis_r;
      end
      S_SUM:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      axis_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      axis_r <= axis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        t_r  <= req.t;
        qx_r <= req.qx;
        qy_r <= req.qy;
      end
      S_T2: t2_r <= 17'((tsq + 34'd32768) >> 16);
      S_T3: t3_r <= 17'((tsq + 34'd32768) >> 16);
      S_COEF: begin
        c0_r <= p1 <<< 1;
        c1_r <= p2 - p0;
        c2_r <= (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
        c3_r <= (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - p0;
      end
      S_M1: acc_r <= (71'(c0_r) <<< 16) + 71'(mul_p);
      S_M2, S_M3: acc_r <= acc_r + 71'(mul_p);
      S_AXIS: begin
        if (axis_r) y_r <= ax_v;
        else x_r <= ax_v;
      end
      S_SQ: begin
        if (axis_r) sy_r <= sq;
        else sx_r <= sq;
      end
      S_SUM: dsq_r <= sum[64] ? '1 : sum[63:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= (st_r == S_SUM);
  end

  // x and y hold until the next request writes new ones
  always_comb begin
    rsp.done = done_r;
    rsp.x    = x_r;
    rsp.y    = y_r;
    rsp.dsq  = dsq_r;
  end

endmodule
